// ===== hdl/wemv_pkg.sv =====
// Shared types and constants for the windowed energy mean/variance unit.
package wemv_pkg;

    localparam int KICK_DEPTH_DEF = 64;
    localparam int MIDL_DEPTH_DEF = 64;

    localparam int SAMPLE_W = 16;
    localparam int MEAN_W   = 16;
    localparam int VAR_W    = 32;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 96;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_MEAN,
        ST_MEAN_DRAIN,
        ST_VAR,
        ST_VAR_DRAIN,
        ST_DONE
    } wemv_state_t;

    typedef struct packed {
        logic ready;
        logic load;
        logic clear;
        logic write;
        logic mean_run;
        logic var_run;
        logic acc_clr;
        logic mean_latch;
        logic cnt_inc;
        logic cnt_clr;
        logic emit;
    } wemv_cmd_t;

    typedef struct packed {
        logic cnt_last;
        logic pipe_empty;
        logic out_stall;
    } wemv_status_t;

endpackage

// ===== hdl/wemv_ctrl.sv =====
// Sequencer: clear sweep, sample write, mean pass, variance pass, result hand-off.
module wemv_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  wemv_pkg::wemv_status_t status,
    output wemv_pkg::wemv_cmd_t    cmd
);

    wemv_pkg::wemv_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wemv_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            wemv_pkg::ST_CLEAR: begin
                cmd.clear   = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (status.cnt_last) begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = wemv_pkg::ST_IDLE;
                end
            end
            wemv_pkg::ST_IDLE: begin
                cmd.ready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = wemv_pkg::ST_WRITE;
                end
            end
            wemv_pkg::ST_WRITE: begin
                cmd.write   = 1'b1;
                cmd.acc_clr = 1'b1;
                cmd.cnt_clr = 1'b1;
                state_next  = wemv_pkg::ST_MEAN;
            end
            wemv_pkg::ST_MEAN: begin
                cmd.mean_run = 1'b1;
                cmd.cnt_inc  = 1'b1;
                if (status.cnt_last) begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = wemv_pkg::ST_MEAN_DRAIN;
                end
            end
            wemv_pkg::ST_MEAN_DRAIN: begin
                if (status.pipe_empty) begin
                    cmd.mean_latch = 1'b1;
                    state_next     = wemv_pkg::ST_VAR;
                end
            end
            wemv_pkg::ST_VAR: begin
                cmd.var_run = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (status.cnt_last) begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = wemv_pkg::ST_VAR_DRAIN;
                end
            end
            wemv_pkg::ST_VAR_DRAIN: begin
                if (status.pipe_empty) begin
                    state_next = wemv_pkg::ST_DONE;
                end
            end
            wemv_pkg::ST_DONE: begin
                if (!status.out_stall) begin
                    cmd.emit   = 1'b1;
                    state_next = wemv_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wemv_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

// ===== hdl/wemv_lane.sv =====
// One band: ring history memory, pointer, and the accumulate/square pipeline.
module wemv_lane #(
    parameter int DEPTH = wemv_pkg::KICK_DEPTH_DEF,
    parameter int CNT_W = $clog2(wemv_pkg::KICK_DEPTH_DEF)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  wemv_pkg::wemv_cmd_t           cmd,
    input  logic [CNT_W-1:0]              cnt,
    input  logic [wemv_pkg::SAMPLE_W-1:0] in_value,
    input  logic                          in_valid,
    output logic [wemv_pkg::MEAN_W-1:0]   mean,
    output logic [wemv_pkg::VAR_W-1:0]    variance,
    output logic                          pipe_empty
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ACC_W  = wemv_pkg::VAR_W + ADDR_W;
    localparam int SQ_W   = wemv_pkg::VAR_W;

    logic [wemv_pkg::SAMPLE_W-1:0] mem [DEPTH];

    logic [wemv_pkg::SAMPLE_W-1:0] sample_reg;
    logic                          valid_reg;
    logic [ADDR_W-1:0]             ptr_reg, ptr_next;
    logic [wemv_pkg::MEAN_W-1:0]   mean_reg;
    logic [ACC_W-1:0]              acc_reg, acc_next;
    logic [wemv_pkg::SAMPLE_W-1:0] rdata_reg;
    logic [wemv_pkg::VAR_W-1:0]    sq_reg;
    logic                          mv1_reg, qv1_reg, qv2_reg;

    logic                          in_range;
    logic                          wr_en, rd_en;
    logic [ADDR_W-1:0]             wr_addr, ptr_inc;
    logic [wemv_pkg::SAMPLE_W-1:0] wr_data, diff;

    assign in_range = ({1'b0, cnt} < (CNT_W + 1)'(DEPTH));
    assign ptr_inc  = ptr_reg + ADDR_W'(1);
    assign wr_en    = (cmd.clear && in_range) || (cmd.write && valid_reg);
    assign wr_addr  = cmd.clear ? cnt[ADDR_W-1:0] : ptr_inc;
    assign wr_data  = cmd.clear ? '0 : sample_reg;
    assign rd_en    = (cmd.mean_run || cmd.var_run) && in_range;
    assign diff     = (rdata_reg >= mean_reg) ? (rdata_reg - mean_reg) : (mean_reg - rdata_reg);
    assign ptr_next = (cmd.write && valid_reg) ? ptr_inc : ptr_reg;

    always_comb begin
        acc_next = acc_reg;
        if (cmd.acc_clr || cmd.mean_latch) begin
            acc_next = '0;
        end else if (mv1_reg) begin
            acc_next = acc_reg + ACC_W'(rdata_reg);
        end else if (qv2_reg) begin
            acc_next = acc_reg + ACC_W'(sq_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[cnt[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sample_reg <= in_value;
        end
        sq_reg <= SQ_W'(diff) * SQ_W'(diff);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            ptr_reg   <= '0;
            mean_reg  <= '0;
            acc_reg   <= '0;
            mv1_reg   <= 1'b0;
            qv1_reg   <= 1'b0;
            qv2_reg   <= 1'b0;
        end else begin
            if (cmd.load) begin
                valid_reg <= in_valid;
            end
            if (cmd.mean_latch) begin
                mean_reg <= acc_reg[ADDR_W +: wemv_pkg::MEAN_W];
            end
            ptr_reg <= ptr_next;
            acc_reg <= acc_next;
            mv1_reg <= cmd.mean_run && in_range;
            qv1_reg <= cmd.var_run && in_range;
            qv2_reg <= qv1_reg;
        end
    end

    assign mean       = mean_reg;
    assign variance   = acc_reg[ADDR_W +: wemv_pkg::VAR_W];
    assign pipe_empty = !mv1_reg && !qv1_reg && !qv2_reg;

endmodule

// ===== hdl/wemv_datapath.sv =====
// Datapath: entry counter, both band lanes and the output beat register.
module wemv_datapath #(
    parameter int KICK_DEPTH = wemv_pkg::KICK_DEPTH_DEF,
    parameter int MIDL_DEPTH = wemv_pkg::MIDL_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  wemv_pkg::wemv_cmd_t           cmd,
    input  logic [wemv_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                          m_tready,
    output wemv_pkg::wemv_status_t        status,
    output logic                          m_tvalid,
    output logic [wemv_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int MAX_DEPTH = (KICK_DEPTH > MIDL_DEPTH) ? KICK_DEPTH : MIDL_DEPTH;
    localparam int CNT_W     = $clog2(MAX_DEPTH);

    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [wemv_pkg::M_DATA_W-1:0] m_tdata_reg;

    logic [wemv_pkg::MEAN_W-1:0]   kick_mean, midl_mean;
    logic [wemv_pkg::VAR_W-1:0]    kick_variance, midl_variance;
    logic                          kick_empty, midl_empty;

    wemv_lane #(.DEPTH(KICK_DEPTH), .CNT_W(CNT_W)) u_kick (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .cnt        (cnt_reg),
        .in_value   (s_tdata[15:0]),
        .in_valid   (s_tdata[16]),
        .mean       (kick_mean),
        .variance   (kick_variance),
        .pipe_empty (kick_empty)
    );

    wemv_lane #(.DEPTH(MIDL_DEPTH), .CNT_W(CNT_W)) u_midl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .cnt        (cnt_reg),
        .in_value   (s_tdata[32:17]),
        .in_valid   (s_tdata[33]),
        .mean       (midl_mean),
        .variance   (midl_variance),
        .pipe_empty (midl_empty)
    );

    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.cnt_clr) begin
            cnt_next = '0;
        end else if (cmd.cnt_inc) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        m_tvalid_next = m_tvalid_reg;
        if (cmd.emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= {midl_variance, midl_mean, kick_variance, kick_mean};
        end
    end

    assign status.cnt_last   = (cnt_reg == CNT_W'(MAX_DEPTH - 1));
    assign status.pipe_empty = kick_empty && midl_empty;
    assign status.out_stall  = m_tvalid_reg && !m_tready;
    assign m_tvalid          = m_tvalid_reg;
    assign m_tdata           = m_tdata_reg;

endmodule

// ===== hdl/windowed_energy_mean_variance_unit.sv =====
// Top level of the windowed energy mean/variance unit.
// Keeps ring histories of kick and mid-low Q8.8 band energies (power-of-two depths)
// and returns one beat per input beat with the floor mean (Q8.8) and floor population
// variance (Q16.16) of each window. One beat at a time is processed: accept, a write,
// then a mean pass and a variance pass, each stepping through max(KICK_DEPTH, MIDL_DEPTH)
// entries of the single-port history memories, then pipeline drain. A result beat
// waiting on m_tready does not stop the next input from being accepted. After reset
// a clearing pass zeroes the histories before s_tready rises.
module windowed_energy_mean_variance_unit #(
    parameter int KICK_DEPTH = wemv_pkg::KICK_DEPTH_DEF,
    parameter int MIDL_DEPTH = wemv_pkg::MIDL_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // kick_value[15:0], kick_valid, midl_value[15:0], midl_valid
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata    // kick_mean[15:0], kick_variance[31:0], midl_mean, midl_variance
);

    wemv_pkg::wemv_cmd_t    cmd;
    wemv_pkg::wemv_status_t status;

    wemv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .status   (status),
        .cmd      (cmd)
    );

    wemv_datapath #(.KICK_DEPTH(KICK_DEPTH), .MIDL_DEPTH(MIDL_DEPTH)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

    assign s_tready = cmd.ready;

    a_emit_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !status.out_stall)
        else $error("result beat overwritten while stalled");

    a_load_on_handshake: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> (s_tvalid && s_tready))
        else $error("sample loaded without input handshake");

    a_one_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.clear, cmd.write, cmd.mean_run, cmd.var_run}))
        else $error("overlapping memory phases");

    a_valid_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.emit))
        else $error("m_tvalid rose without emit");

endmodule
